// ----- design/fatan_pkg.sv -----
// Shared widths, Q30 constants, special-case codes and sideband type for the atan2 pipeline.
package fatan_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_W         = ANGLE_FRAC_BITS + 3;

  // Magnitudes of the coordinates; the most negative value still fits unsigned.
  localparam int MAG_W   = COORD_WIDTH;
  // Ratio z is Q1.15.
  localparam int Z_FRAC  = 15;
  localparam int Q_W     = Z_FRAC + 1;
  localparam int Z_W     = Z_FRAC + 2;
  localparam int Z2_W    = 2 * Z_FRAC + 1;
  // Dividend is (num << (Z_FRAC+1)) + den, divisor is 2*den.
  localparam int DVD_W   = MAG_W + Z_FRAC + 1;
  localparam int DVS_W   = MAG_W + 1;

  localparam int Q30_FRAC     = 30;
  localparam int ACC_W        = 32;
  localparam int P_W          = 34;
  localparam int HORNER_STEPS = 4;
  localparam int OUT_SHIFT    = Q30_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [P_W-1:0]   Q30_PI      = 34'sd3373259426;
  localparam logic signed [P_W-1:0]   Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [ACC_W-1:0] Q30_C9      = 32'sd22371518;

  // Term added after each Horner product, signs folded in.
  localparam logic signed [ACC_W-1:0] HORNER_ADD [HORNER_STEPS] = '{
    -32'sd91410863,
     32'sd193424926,
    -32'sd354656388,
     32'sd1073597943
  };

  // Special-case codes.
  localparam logic [2:0] SPEC_NONE  = 3'd0;
  localparam logic [2:0] SPEC_ZERO  = 3'd1;
  localparam logic [2:0] SPEC_PI    = 3'd2;
  localparam logic [2:0] SPEC_PHALF = 3'd3;
  localparam logic [2:0] SPEC_NHALF = 3'd4;

  typedef struct packed {
    logic       steep;
    logic       xneg;
    logic       yneg;
    logic       zneg;
    logic [2:0] spec;
  } side_t;

endpackage

// ----- design/fast_atan2_poly.sv -----
// Top level of the four-quadrant atan2 pipeline (ratio divider plus degree-9 polynomial).
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   input   | in_valid, in_ready, y_coord, x_coord  | request in
//   output  | out_valid, out_ready, angle           | request out
//
// One request enters per cycle while the output is not stalled; each result passes through the
// input register, 16 divider stages (one quotient bit each), square stage, two stages per
// Horner step (four steps), multiply/reflect/quadrant stages and the output register.
// Every stage moves under one shared enable; a result held at the output holds all
// stages and drops in_ready, so nothing is lost or repeated.
// Reset clears only the valid bits; payload registers carry no reset.
module fast_atan2_poly (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [fatan_pkg::COORD_WIDTH-1:0] y_coord,
  input  logic signed [fatan_pkg::COORD_WIDTH-1:0] x_coord,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fatan_pkg::ANGLE_W-1:0]   angle
);
  import fatan_pkg::*;

  localparam int MSB = COORD_WIDTH - 1;
  localparam logic signed [P_W-1:0]     RND_OUT   = P_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [P_W-1:0]     PI_ROUND  = Q30_PI + RND_OUT;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(PI_ROUND >>> OUT_SHIFT);

  // Advance the whole pipe unless a result is stuck at the output.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Front stage: magnitudes, octant choice, special cases.
  logic [MAG_W-1:0] ay;
  logic [MAG_W-1:0] ax;
  logic [MAG_W-1:0] num;
  logic [MAG_W-1:0] den;
  logic             steep;
  side_t            side_next;

  assign ay    = y_coord[MSB] ? MAG_W'(-y_coord) : MAG_W'(y_coord);
  assign ax    = x_coord[MSB] ? MAG_W'(-x_coord) : MAG_W'(x_coord);
  assign steep = ay > ax;
  assign num   = steep ? ax : ay;
  assign den   = steep ? ay : ax;

  always_comb begin
    side_next.steep = steep;
    side_next.xneg  = x_coord[MSB];
    side_next.yneg  = y_coord[MSB];
    side_next.zneg  = x_coord[MSB] ^ y_coord[MSB];
    if (x_coord == '0 && y_coord == '0) begin
      side_next.spec = SPEC_ZERO;
    end else if (y_coord == '0) begin
      side_next.spec = x_coord[MSB] ? SPEC_PI : SPEC_ZERO;
    end else if (x_coord == '0) begin
      side_next.spec = y_coord[MSB] ? SPEC_NHALF : SPEC_PHALF;
    end else begin
      side_next.spec = SPEC_NONE;
    end
  end

  logic             a_vld;
  logic [DVD_W-1:0] a_dvd;
  logic [DVS_W-1:0] a_dvs;
  side_t            a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  // Dividend carries +den so the quotient rounds to nearest.
  always_ff @(posedge clk) begin
    if (en) begin
      a_dvd  <= (DVD_W'(num) << (Z_FRAC + 1)) + DVD_W'(den);
      a_dvs  <= {den, 1'b0};
      a_side <= side_next;
    end
  end

  // Ratio magnitude in Q1.15.
  logic           d_vld;
  logic [Q_W-1:0] d_quot;
  side_t          d_side;

  fatan_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (a_vld),
    .dividend (a_dvd),
    .divisor  (a_dvs),
    .side_in  (a_side),
    .out_vld  (d_vld),
    .quot     (d_quot),
    .side_out (d_side)
  );

  // Angle in Q30 after reflection and quadrant fix-up.
  logic                  p_vld;
  logic signed [P_W-1:0] p_q30;

  fatan_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (d_vld),
    .zmag      (d_quot),
    .side_in   (d_side),
    .out_vld   (p_vld),
    .angle_q30 (p_q30)
  );

  // Output register: round half up to Q2.ANGLE_FRAC_BITS.
  logic signed [P_W-1:0] out_sum;
  assign out_sum = p_q30 + RND_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= ANGLE_W'(out_sum >>> OUT_SHIFT);
    end
  end

  // A result never exceeds pi in magnitude.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle <= ANGLE_MAX) && (angle >= -ANGLE_MAX))
    else $error("angle outside +/-pi");

  // A held result must block new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while output stalled");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ----- design/fatan_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
module fatan_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [fatan_pkg::DVD_W-1:0] dividend,
  input  logic [fatan_pkg::DVS_W-1:0] divisor,
  input  fatan_pkg::side_t            side_in,
  output logic                        out_vld,
  output logic [fatan_pkg::Q_W-1:0]   quot,
  output fatan_pkg::side_t            side_out
);
  import fatan_pkg::*;

  localparam int REM_W = DVD_W + 1;

  logic             vld  [Q_W];
  logic [DVD_W-1:0] rem  [Q_W];
  logic [DVS_W-1:0] dvs  [Q_W];
  logic [Q_W-1:0]   q    [Q_W];
  side_t            side [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int BIT = Q_W - 1 - i;

    logic             vld_in;
    logic [DVD_W-1:0] rem_in;
    logic [DVS_W-1:0] dvs_in;
    logic [Q_W-1:0]   q_in;
    side_t            side_in_s;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] diff;
    logic             fits;

    if (i == 0) begin : g_first
      assign vld_in    = in_vld;
      assign rem_in    = dividend;
      assign dvs_in    = divisor;
      assign q_in      = '0;
      assign side_in_s = side_in;
    end else begin : g_next
      assign vld_in    = vld[i-1];
      assign rem_in    = rem[i-1];
      assign dvs_in    = dvs[i-1];
      assign q_in      = q[i-1];
      assign side_in_s = side[i-1];
    end

    assign shifted = REM_W'(dvs_in) << BIT;
    assign diff    = {1'b0, rem_in} - shifted;
    assign fits    = {1'b0, rem_in} >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= fits ? diff[DVD_W-1:0] : rem_in;
        dvs[i]  <= dvs_in;
        q[i]    <= q_in | (fits ? (Q_W'(1) << BIT) : '0);
        side[i] <= side_in_s;
      end
    end
  end

  assign out_vld  = vld[Q_W-1];
  assign quot     = q[Q_W-1];
  assign side_out = side[Q_W-1];

endmodule

// ----- design/fatan_poly.sv -----
// Odd degree-9 arctangent polynomial, reflection and quadrant fix-up, fully pipelined.
module fatan_poly (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [fatan_pkg::Q_W-1:0]         zmag,
  input  fatan_pkg::side_t                  side_in,
  output logic                              out_vld,
  output logic signed [fatan_pkg::P_W-1:0]  angle_q30
);
  import fatan_pkg::*;

  localparam int PROD_W  = 2 * ACC_W;
  localparam int PROD1_W = ACC_W + Z_W;
  localparam logic signed [PROD_W-1:0]  RND30 = PROD_W'(1) << (Q30_FRAC - 1);
  localparam logic signed [PROD1_W-1:0] RND15 = PROD1_W'(1) << (Z_FRAC - 1);

  typedef struct packed {
    logic signed [Z_W-1:0] z;
    logic [Z2_W-1:0]       z2;
    side_t                 side;
  } ctx_t;

  // Ratio sign and square.
  logic                  z_vld;
  ctx_t                  z_ctx;
  logic signed [Z_W-1:0] z_next;
  logic [2*Q_W-1:0]      sq;

  assign z_next = side_in.zneg ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
  assign sq     = (2*Q_W)'(zmag) * (2*Q_W)'(zmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      z_vld <= 1'b0;
    end else if (en) begin
      z_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_ctx.z    <= z_next;
      z_ctx.z2   <= sq[Z2_W-1:0];
      z_ctx.side <= side_in;
    end
  end

  // Horner steps: multiply stage, then round-and-add stage.
  logic                     m_vld  [HORNER_STEPS];
  logic signed [PROD_W-1:0] m_prod [HORNER_STEPS];
  logic signed [ACC_W-1:0]  m_add  [HORNER_STEPS];
  ctx_t                     m_ctx  [HORNER_STEPS];
  logic                     h_vld  [HORNER_STEPS];
  logic signed [ACC_W-1:0]  h_acc  [HORNER_STEPS];
  ctx_t                     h_ctx  [HORNER_STEPS];

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    logic                     a_vld;
    logic signed [ACC_W-1:0]  a_acc;
    ctx_t                     a_ctx;
    logic signed [PROD_W-1:0] rnd_sum;

    if (j == 0) begin : g_first
      assign a_vld = z_vld;
      assign a_acc = Q30_C9;
      assign a_ctx = z_ctx;
    end else begin : g_next
      assign a_vld = h_vld[j-1];
      assign a_acc = h_acc[j-1];
      assign a_ctx = h_ctx[j-1];
    end

    assign rnd_sum = m_prod[j] + RND30;

    always_ff @(posedge clk) begin
      if (rst) begin
        m_vld[j] <= 1'b0;
        h_vld[j] <= 1'b0;
      end else if (en) begin
        m_vld[j] <= a_vld;
        h_vld[j] <= m_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_prod[j] <= PROD_W'(a_acc) * PROD_W'($signed({1'b0, a_ctx.z2}));
        m_add[j]  <= HORNER_ADD[j];
        m_ctx[j]  <= a_ctx;
        h_acc[j]  <= ACC_W'(rnd_sum >>> Q30_FRAC) + m_add[j];
        h_ctx[j]  <= m_ctx[j];
      end
    end
  end

  // Final multiply by z, round to Q30, reflect, then fix the quadrant.
  logic                      p1_vld;
  logic signed [PROD1_W-1:0] p1_prod;
  side_t                     p1_side;
  logic                      p2_vld;
  logic signed [P_W-1:0]     p2_val;
  side_t                     p2_side;
  logic                      p3_vld;
  logic signed [P_W-1:0]     p3_val;

  logic signed [PROD1_W-1:0] p1_sum;
  logic signed [P_W-1:0]     r15;
  logic signed [P_W-1:0]     half;
  logic signed [P_W-1:0]     p3_next;

  assign p1_sum = p1_prod + RND15;
  assign r15    = P_W'(p1_sum >>> Z_FRAC);
  assign half   = p1_side.zneg ? -Q30_HALF_PI : Q30_HALF_PI;

  always_comb begin
    unique case (p2_side.spec)
      SPEC_NONE: begin
        if (p2_side.xneg) begin
          p3_next = p2_side.yneg ? p2_val - Q30_PI : p2_val + Q30_PI;
        end else begin
          p3_next = p2_val;
        end
      end
      SPEC_ZERO:  p3_next = '0;
      SPEC_PI:    p3_next = Q30_PI;
      SPEC_PHALF: p3_next = Q30_HALF_PI;
      SPEC_NHALF: p3_next = -Q30_HALF_PI;
      default:    p3_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= h_vld[HORNER_STEPS-1];
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_prod <= PROD1_W'(h_acc[HORNER_STEPS-1]) *
                 PROD1_W'($signed(h_ctx[HORNER_STEPS-1].z));
      p1_side <= h_ctx[HORNER_STEPS-1].side;
      p2_val  <= p1_side.steep ? half - r15 : r15;
      p2_side <= p1_side;
      p3_val  <= p3_next;
    end
  end

  assign out_vld   = p3_vld;
  assign angle_q30 = p3_val;

endmodule

// ----- sim/fast_atan2_poly_test.sv -----
// Self-checking testbench for the fast_atan2_poly angle pipeline, with a scoreboard class.
module fast_atan2_poly_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fatan_pkg::*;

  // Radian constants and odd-polynomial coefficients, all Q30, rounded to nearest.
  localparam longint RAD_PI      = 64'sd3373259426;
  localparam longint RAD_HALF_PI = 64'sd1686629713;
  localparam longint COEF_9      = 64'sd22371518;
  localparam longint COEF_7      = 64'sd91410863;
  localparam longint COEF_5      = 64'sd193424926;
  localparam longint COEF_3      = 64'sd354656388;
  localparam longint COEF_1      = 64'sd1073597943;

  // Bits of the ratio z below the binary point, and bits of Q30.
  localparam int RATIO_FRAC = 15;
  localparam int FRAC_Q30   = 30;

  localparam int RANDOM_REQUESTS = 650;
  localparam int IDLE_PERCENT    = 22;
  // Give the pipeline tail some margin after the last drain.
  localparam int DRAIN_CYCLES    = 40;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0]     angle_t;

  typedef struct {
    coord_t y;
    coord_t x;
    angle_t angle;
  } pending_angle_t;

  // Predict the angle of each accepted request and match it against the
  // results in order.
  class angle_scoreboard;
    pending_angle_t pending_angles[$];
    int mismatches;
    int checked;

    // Round half up while shifting right: floor((v + half) / 2^s).
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function angle_t predict_angle(coord_t y_in, coord_t x_in);
      longint y, x, ay, ax, num, den, mag, z, z2, acc, rad;
      bit     steep;
      y = y_in;
      x = x_in;
      if (y == 0 && x == 0) begin
        rad = 0;
      end else if (y == 0) begin
        rad = (x > 0) ? 0 : RAD_PI;
      end else if (x == 0) begin
        rad = (y > 0) ? RAD_HALF_PI : -RAD_HALF_PI;
      end else begin
        ay    = (y < 0) ? -y : y;
        ax    = (x < 0) ? -x : x;
        // On a tie x stays the divisor, so |z| is one and no reflection happens.
        steep = ay > ax;
        num   = steep ? ax : ay;
        den   = steep ? ay : ax;
        mag   = ((num <<< (RATIO_FRAC + 1)) + den) / (den <<< 1);
        z     = ((x < 0) != (y < 0)) ? -mag : mag;
        z2    = z * z;
        acc   = COEF_9;
        acc   = round_shift(acc * z2, FRAC_Q30) - COEF_7;
        acc   = round_shift(acc * z2, FRAC_Q30) + COEF_5;
        acc   = round_shift(acc * z2, FRAC_Q30) - COEF_3;
        acc   = round_shift(acc * z2, FRAC_Q30) + COEF_1;
        rad   = round_shift(acc * z, RATIO_FRAC);
        if (steep) begin
          rad = ((z > 0) ? RAD_HALF_PI : -RAD_HALF_PI) - rad;
        end
        if (x < 0) begin
          rad = (y < 0) ? rad - RAD_PI : rad + RAD_PI;
        end
      end
      rad = round_shift(rad, FRAC_Q30 - ANGLE_FRAC_BITS);
      return rad[ANGLE_W-1:0];
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: MISMATCH %s", $time, what);
      mismatches++;
    endtask

    function void note_request(coord_t y, coord_t x);
      pending_angle_t entry;
      entry.y     = y;
      entry.x     = x;
      entry.angle = predict_angle(y, x);
      pending_angles.push_back(entry);
    endfunction

    task check_result(angle_t angle);
      pending_angle_t entry;
      checked++;
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("angle %0d arrived with no request waiting", angle));
      end else begin
        entry = pending_angles.pop_front();
        if (angle !== entry.angle) begin
          report_mismatch($sformatf("angle for y=%0d x=%0d is %0d, predicted %0d",
                                    entry.y, entry.x, angle, entry.angle));
        end
      end
    endtask

    function int outstanding();
      return pending_angles.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t y_coord = '0;
  coord_t x_coord = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  angle_t angle;

  // Set during a long stretch in which neither side idles.
  bit quiet_stretch = 1'b0;
  int requests_sent = 0;

  angle_scoreboard angles_sb = new();

  fast_atan2_poly u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .y_coord   (y_coord),
    .x_coord   (x_coord),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle     (angle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request, idling first at random; call and return at a falling edge.
  // Only the low COORD_WIDTH bits of each value are sent.
  task automatic send_request(input int y_val, input int x_val);
    while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    y_coord  <= coord_t'(y_val);
    x_coord  <= coord_t'(x_val);
    // Hold the request until the pipeline takes it.
    do @(posedge clk); while (!in_ready);
    angles_sb.note_request(coord_t'(y_val), coord_t'(x_val));
    requests_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted angle has come back.
  task automatic drain_angles();
    in_valid <= 1'b0;
    while (angles_sb.outstanding() != 0) @(negedge clk);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  // Stall the result side at random, except during the quiet stretch.
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Sample results at the rising edge, where the handshake happens.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      angles_sb.check_result(angle);
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d angles still expected", angles_sb.outstanding());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int kind, yi, xi, directed;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Origin and the four axis directions, with their extreme magnitudes.
    send_request(0, 0);
    send_request(0, 1);
    send_request(0, -1);
    send_request(0, 32767);
    send_request(0, -32768);
    send_request(1, 0);
    send_request(-1, 0);
    send_request(32767, 0);
    send_request(-32768, 0);
    // Equal or nearly equal magnitudes in every quadrant; for equal ones the ratio is exactly one.
    send_request(1, 1);
    send_request(-1, -1);
    send_request(1, -1);
    send_request(-1, 1);
    send_request(32767, 32767);
    send_request(-32768, -32768);
    send_request(-32768, 32767);
    send_request(32767, -32768);
    // Steepest and flattest ratios, near the axes on both sides.
    send_request(1, 32767);
    send_request(32767, 1);
    send_request(-1, -32768);
    send_request(-32768, -1);
    send_request(-32768, 1);
    send_request(1, -32768);
    directed = requests_sent;
    drain_angles();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      quiet_stretch = (n >= 250 && n < 400);
      // Pause the sender twice until the pipeline is empty.
      if (n == 150 || n == 500) begin
        drain_angles();
      end
      kind = $urandom_range(99);
      if (kind < 55) begin
        yi = int'($urandom_range(65535)) - 32768;
        xi = int'($urandom_range(65535)) - 32768;
      end else if (kind < 70) begin
        yi = int'($urandom_range(16)) - 8;
        xi = int'($urandom_range(16)) - 8;
      end else if (kind < 82) begin
        // Equal or nearly equal magnitudes, around the reflection boundary.
        xi = int'($urandom_range(65535)) - 32768;
        yi = ($urandom_range(1) ? xi : -xi) + int'($urandom_range(2)) - 1;
      end else if (kind < 92) begin
        yi = int'($urandom_range(65535)) - 32768;
        xi = 0;
        if ($urandom_range(1)) begin
          xi = yi;
          yi = 0;
        end
      end else begin
        yi = pick_extreme();
        xi = pick_extreme();
      end
      send_request(yi, xi);
    end
    quiet_stretch = 1'b0;
    drain_angles();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d coordinate pairs (%0d directed, rest random) and checked %0d angles",
             requests_sent, directed, angles_sb.checked);
    $display("Covered origin, axes, ties, extremes, all quadrants; %0d mismatches",
             angles_sb.mismatches);
    if (angles_sb.mismatches == 0 && angles_sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- fast_atan2_poly.f -----
design/fatan_pkg.sv
design/fatan_div.sv
design/fatan_poly.sv
design/fast_atan2_poly.sv
sim/fast_atan2_poly_test.sv
